[src/smx_pkg.sv]
package smx_pkg;

   localparam int FUNC_BITS = 4;
   localparam int PUSH_BITS = 32;
   localparam int TARGET_BITS = 16;
   localparam int VAR_IDX_BITS = 10;
   localparam int NEXT_PC_BITS = 16;
   localparam int TOP_BITS = 32;
   localparam int DEPTH_BITS = 11;
   localparam int STATUS_BITS = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_NOP   = 4'd0,
      OP_PUSH  = 4'd1,
      OP_POP   = 4'd2,
      OP_LOAD  = 4'd3,
      OP_STORE = 4'd4,
      OP_ADD   = 4'd5,
      OP_SUB   = 4'd6,
      OP_MUL   = 4'd7,
      OP_OR    = 4'd8,
      OP_AND   = 4'd9,
      OP_NOT   = 4'd10,
      OP_JMP   = 4'd11,
      OP_JZ    = 4'd12,
      OP_JP    = 4'd13,
      OP_JM    = 4'd14,
      OP_HALT  = 4'd15
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_RUN   = 2'd0,
      ST_HALT  = 2'd1,
      ST_OVER  = 2'd2,
      ST_UNDER = 2'd3
   } status_type;

   typedef struct packed {
      logic stk_we;
      logic var_we;
   } ctl_type;

endpackage

[src/smx_var_store.sv]
module smx_var_store
   import smx_pkg::*;
#(
   parameter int VARIABLE_COUNT = 1024,
   parameter int DATA_BITS = 32,
   parameter int VA_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [VA_BITS-1:0]   rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [VA_BITS-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic                 busy
);

   localparam logic [VA_BITS-1:0] VA_LAST = VA_BITS'(VARIABLE_COUNT - 1);

   logic [DATA_BITS-1:0] mem [0:VARIABLE_COUNT-1];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [VA_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic                 clr_busy_ff, clr_busy_in;
   logic                 we;
   logic [VA_BITS-1:0]   wa;
   logic [DATA_BITS-1:0] wd;

   // sweep of zeros after reset
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == VA_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   assign we = clr_busy_ff || wr_en;
   assign wa = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign wd = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         if (we && (wa == rd_addr)) begin
            rd_data_ff <= wd;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy = clr_busy_ff;

endmodule

[src/smx_stack_ram.sv]
module smx_stack_ram
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int DATA_BITS = 32,
   parameter int SI_BITS = 10
) (
   input  logic                 clock,
   input  logic [SI_BITS-1:0]   rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [SI_BITS-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [0:STACK_DEPTH-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   // entries below the two cached top entries; write-through on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/smx_exec.sv]
module smx_exec
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int VARIABLE_COUNT = 1024,
   parameter int PC_BITS = 16,
   parameter int DATA_BITS = 32,
   parameter int SP_BITS = 11
) (
   input  op_type                      func,
   input  logic signed [PUSH_BITS-1:0] push_value,
   input  logic [TARGET_BITS-1:0]      jump_target,
   input  logic [VAR_IDX_BITS-1:0]     var_index,
   input  logic [DATA_BITS-1:0]        var_data,
   input  logic [PC_BITS-1:0]          pc,
   input  logic [SP_BITS-1:0]          sp,
   input  logic [DATA_BITS-1:0]        top,
   input  logic [DATA_BITS-1:0]        second,
   input  logic [DATA_BITS-1:0]        third,
   input  status_type                  status,
   output logic [PC_BITS-1:0]          pc_in,
   output logic [SP_BITS-1:0]          sp_in,
   output logic [DATA_BITS-1:0]        top_in,
   output logic [DATA_BITS-1:0]        second_in,
   output status_type                  status_in,
   output ctl_type                     ctl
);

   localparam logic [SP_BITS-1:0] SP_FULL = SP_BITS'(STACK_DEPTH);
   localparam logic [SP_BITS-1:0] SP_ONE = SP_BITS'(1);
   localparam logic [SP_BITS-1:0] SP_TWO = SP_BITS'(2);

   logic [PC_BITS-1:0]   pc_inc, tgt;
   logic [DATA_BITS-1:0] pv, load_val, prod;
   logic [SP_BITS-1:0]   need;
   logic                 var_ok, take;

   assign pc_inc = pc + 1'b1;
   assign tgt = PC_BITS'(jump_target);
   assign pv = DATA_BITS'(push_value);
   assign var_ok = 32'(var_index) < VARIABLE_COUNT;
   assign load_val = var_ok ? var_data : '0;
   assign prod = second * top;

   always_comb begin
      case (func)
         OP_POP, OP_STORE, OP_NOT, OP_JZ, OP_JP, OP_JM: need = SP_ONE;
         OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND:         need = SP_TWO;
         default:                                      need = '0;
      endcase
   end

   always_comb begin
      case (func)
         OP_JZ:   take = (top == '0);
         OP_JP:   take = (top != '0) && !top[DATA_BITS-1];
         OP_JM:   take = top[DATA_BITS-1];
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc;
      sp_in = sp;
      top_in = top;
      second_in = second;
      status_in = status;
      ctl = '0;
      if (status != ST_RUN) begin
         status_in = status;
      end else if (sp < need) begin
         status_in = ST_UNDER;
      end else if (((func == OP_PUSH) || (func == OP_LOAD)) && (sp >= SP_FULL)) begin
         status_in = ST_OVER;
      end else begin
         pc_in = pc_inc;
         unique case (func)
            OP_NOP: begin
            end
            OP_PUSH, OP_LOAD: begin
               sp_in = sp + 1'b1;
               top_in = (func == OP_PUSH) ? pv : load_val;
               second_in = top;
               ctl.stk_we = (sp >= SP_TWO);
            end
            OP_POP, OP_STORE: begin
               sp_in = sp - 1'b1;
               top_in = second;
               second_in = third;
               ctl.var_we = (func == OP_STORE) && var_ok;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND: begin
               sp_in = sp - 1'b1;
               second_in = third;
               case (func)
                  OP_ADD:  top_in = second + top;
                  OP_SUB:  top_in = second - top;
                  OP_MUL:  top_in = prod;
                  OP_OR:   top_in = second | top;
                  default: top_in = second & top;
               endcase
            end
            OP_NOT: begin
               top_in = {{(DATA_BITS-1){1'b0}}, (top == '0)};
            end
            OP_JMP: begin
               pc_in = tgt;
            end
            OP_JZ, OP_JP, OP_JM: begin
               sp_in = sp - 1'b1;
               top_in = second;
               second_in = third;
               pc_in = take ? tgt : pc_inc;
            end
            OP_HALT: begin
               pc_in = pc;
               status_in = ST_HALT;
            end
            default: begin
               pc_in = pc;
            end
         endcase
      end
   end

endmodule

[src/stack_machine_execute.sv]
// Execute unit of a sixteen-opcode stack machine.
// req_* carries one instruction (opcode, push constant, jump target, variable
// slot) per item; rsp_* returns one item per instruction with the program
// counter to fetch next, the top of stack (zero when empty), the depth and
// the status (running, halted, overflow, underflow).
// Both channels use valid/stall; an item moves when valid is high and stall
// low. The instruction is registered together with the variable-store read,
// executed against the cached top two stack entries and registered into the
// result. One item is taken every cycle while rsp_stall is low, the limit
// being the single execute stage that updates the stack pointer and program
// counter.
// After reset the variable store is swept to zero, one entry a cycle, and
// req_stall stays high until the sweep ends. The stack starts empty, the
// program counter at one and the status at running. A stop is sticky.
// While rsp_stall is high the result holds and one further instruction
// waits in the input register; then req_stall rises.
module stack_machine_execute
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int VARIABLE_COUNT = 1024,
   parameter int PC_BITS = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [FUNC_BITS-1:0]          req_func,
   input  logic signed [PUSH_BITS-1:0]   req_push_value,
   input  logic [TARGET_BITS-1:0]        req_jump_target,
   input  logic [VAR_IDX_BITS-1:0]       req_var_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NEXT_PC_BITS-1:0]       rsp_next_pc,
   output logic signed [TOP_BITS-1:0]    rsp_top_value,
   output logic [DEPTH_BITS-1:0]         rsp_stack_depth,
   output logic [STATUS_BITS-1:0]        rsp_status
);

   localparam int SP_BITS = $clog2(STACK_DEPTH + 1);
   localparam int SI_BITS = $clog2(STACK_DEPTH);
   localparam int VA_BITS = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
   localparam logic [PC_BITS-1:0] PC_RESET = PC_BITS'(1);
   localparam logic [SP_BITS-1:0] SP_THREE = SP_BITS'(3);
   localparam logic [SP_BITS-1:0] SP_TWO = SP_BITS'(2);

   logic                          ex_valid_ff, ex_valid_in;
   op_type                        ex_func_ff;
   logic signed [PUSH_BITS-1:0]   ex_push_ff;
   logic [TARGET_BITS-1:0]        ex_target_ff;
   logic [VAR_IDX_BITS-1:0]       ex_var_ff;

   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [SP_BITS-1:0]   sp_ff, sp_in;
   logic [DATA_BITS-1:0] top_ff, top_in;
   logic [DATA_BITS-1:0] second_ff, second_in;
   status_type           status_ff, status_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [NEXT_PC_BITS-1:0]       rsp_pc_ff;
   logic [TOP_BITS-1:0]           rsp_top_ff;
   logic [DEPTH_BITS-1:0]         rsp_depth_ff;
   status_type                    rsp_status_ff;

   logic                 accept, fire, clearing;
   logic [DATA_BITS-1:0] var_data, third;
   ctl_type              ctl;
   logic [SP_BITS-1:0]   sp_rd, sp_wr;

   assign fire = ex_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing || (ex_valid_ff && !fire);
   assign accept = req_valid && !req_stall;

   assign ex_valid_in = accept ? 1'b1 : (fire ? 1'b0 : ex_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff <= PC_RESET;
         sp_ff <= '0;
         status_ff <= ST_RUN;
      end else begin
         ex_valid_ff <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pc_ff <= pc_in;
            sp_ff <= sp_in;
            status_ff <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_func_ff <= op_type'(req_func);
         ex_push_ff <= req_push_value;
         ex_target_ff <= req_jump_target;
         ex_var_ff <= req_var_index;
      end
      if (fire) begin
         top_ff <= top_in;
         second_ff <= second_in;
         rsp_pc_ff <= NEXT_PC_BITS'(pc_in);
         rsp_top_ff <= (sp_in != '0) ? TOP_BITS'(top_in) : '0;
         rsp_depth_ff <= DEPTH_BITS'(sp_in);
         rsp_status_ff <= status_in;
      end
   end

   smx_var_store #(
      .VARIABLE_COUNT(VARIABLE_COUNT),
      .DATA_BITS(DATA_BITS),
      .VA_BITS(VA_BITS)
   ) u_var (
      .clock(clock),
      .reset(reset),
      .rd_en(accept),
      .rd_addr(VA_BITS'(req_var_index)),
      .rd_data(var_data),
      .wr_en(fire && ctl.var_we),
      .wr_addr(VA_BITS'(ex_var_ff)),
      .wr_data(top_ff),
      .busy(clearing)
   );

   // third entry tracks the stack pointer that is about to be committed
   assign sp_rd = (fire ? sp_in : sp_ff) - SP_THREE;
   assign sp_wr = sp_ff - SP_TWO;

   smx_stack_ram #(
      .STACK_DEPTH(STACK_DEPTH),
      .DATA_BITS(DATA_BITS),
      .SI_BITS(SI_BITS)
   ) u_stack (
      .clock(clock),
      .rd_addr(SI_BITS'(sp_rd)),
      .rd_data(third),
      .wr_en(fire && ctl.stk_we),
      .wr_addr(SI_BITS'(sp_wr)),
      .wr_data(second_ff)
   );

   smx_exec #(
      .STACK_DEPTH(STACK_DEPTH),
      .VARIABLE_COUNT(VARIABLE_COUNT),
      .PC_BITS(PC_BITS),
      .DATA_BITS(DATA_BITS),
      .SP_BITS(SP_BITS)
   ) u_exec (
      .func(ex_func_ff),
      .push_value(ex_push_ff),
      .jump_target(ex_target_ff),
      .var_index(ex_var_ff),
      .var_data(var_data),
      .pc(pc_ff),
      .sp(sp_ff),
      .top(top_ff),
      .second(second_ff),
      .third(third),
      .status(status_ff),
      .pc_in(pc_in),
      .sp_in(sp_in),
      .top_in(top_in),
      .second_in(second_in),
      .status_in(status_in),
      .ctl(ctl)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_pc = rsp_pc_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_status = rsp_status_ff;

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_RUN) |=> (status_ff == $past(status_ff)))
      else $error("stop status changed after a stop");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_BITS'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(sp_ff) && $stable(pc_ff)))
      else $error("machine state moved without an executed item");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!accept && !ex_valid_ff))
      else $error("item taken during variable store sweep");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import smx_pkg::*;

   localparam int STACK_LIMIT = 1024;
   localparam int VAR_SLOTS = 1024;
   localparam int DIRECTED_COUNT = 31;
   localparam int RANDOM_ITEMS = 1850;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 16;

   typedef struct packed {
      op_type            op;
      logic [31:0]       push;
      logic [15:0]       target;
      logic [9:0]        slot;
   } instruction_type;

   typedef struct packed {
      logic [15:0]       pc;
      logic [31:0]       top;
      logic [10:0]       depth;
      status_type        status;
   } outcome_type;

   typedef struct packed {
      instruction_type   ins;
      logic              typed;
      outcome_type       want;
   } instruction_row_type;

   typedef enum int {STOP_BY_HALT, STOP_BY_OVERFLOW, STOP_BY_UNDERFLOW} stop_plan_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [FUNC_BITS-1:0]    req_func = '0;
   logic signed [31:0]      req_push_value = '0;
   logic [15:0]             req_jump_target = '0;
   logic [9:0]              req_var_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [15:0]             rsp_next_pc;
   logic signed [31:0]      rsp_top_value;
   logic [10:0]             rsp_stack_depth;
   logic [1:0]              rsp_status;

   // predicted machine state
   logic [31:0]             operand_stack [STACK_LIMIT];
   logic [31:0]             variables [VAR_SLOTS];
   int                      stack_count = 0;
   int                      deepest = 0;
   logic [15:0]             program_counter = 16'd1;
   status_type              machine_status = ST_RUN;

   outcome_type             pending_results [$];
   int                      mismatches = 0;
   int                      items_issued = 0;
   int                      results_checked = 0;
   int                      burst_left = 0;
   int                      idle_cycles = 0;
   int                      stall_mode = 0;
   int                      stall_run = 0;
   int                      mode_age = 0;
   stop_plan_type           stop_plan;

   instruction_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{OP_NOP,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd2,  32'h0,        11'd0, ST_RUN}},
      '{'{OP_LOAD,  32'h0,        16'h0,    10'd1023}, 1'b1, '{16'd3,  32'h0,        11'd1, ST_RUN}},
      '{'{OP_PUSH,  32'h7fffffff, 16'h0,    10'd0},    1'b1, '{16'd4,  32'h7fffffff, 11'd2, ST_RUN}},
      '{'{OP_ADD,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd5,  32'h7fffffff, 11'd1, ST_RUN}},
      '{'{OP_PUSH,  32'h1,        16'h0,    10'd0},    1'b1, '{16'd6,  32'h1,        11'd2, ST_RUN}},
      '{'{OP_ADD,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd7,  32'h80000000, 11'd1, ST_RUN}},
      '{'{OP_PUSH,  32'h80000000, 16'h0,    10'd0},    1'b1, '{16'd8,  32'h80000000, 11'd2, ST_RUN}},
      '{'{OP_MUL,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd9,  32'h0,        11'd1, ST_RUN}},
      '{'{OP_NOT,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd10, 32'h1,        11'd1, ST_RUN}},
      '{'{OP_NOT,   32'h0,        16'h0,    10'd0},    1'b1, '{16'd11, 32'h0,        11'd1, ST_RUN}},
      '{'{OP_PUSH,  32'hffffffff, 16'h0,    10'd0},    1'b0, '0},
      '{'{OP_STORE, 32'h0,        16'h0,    10'd1023}, 1'b0, '0},
      '{'{OP_LOAD,  32'h0,        16'h0,    10'd1023}, 1'b0, '0},
      '{'{OP_SUB,   32'h0,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'h0f0f0f0f, 16'h0,    10'd0},    1'b0, '0},
      '{'{OP_OR,    32'h0,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'hf0f0f0f0, 16'h0,    10'd0},    1'b0, '0},
      '{'{OP_AND,   32'h0,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_JZ,    32'h0,        16'habcd, 10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'h80000000, 16'h0,    10'd0},    1'b0, '0},
      '{'{OP_JP,    32'h0,        16'h1234, 10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'h5,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_JP,    32'h0,        16'h5555, 10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'hffffffff, 16'h0,    10'd0},    1'b0, '0},
      '{'{OP_JM,    32'h0,        16'hffff, 10'd0},    1'b0, '0},
      '{'{OP_NOP,   32'h0,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'h7,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_PUSH,  32'h9,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_POP,   32'h0,        16'h0,    10'd0},    1'b0, '0},
      '{'{OP_JZ,    32'h0,        16'h9999, 10'd0},    1'b0, '0},
      '{'{OP_JMP,   32'h0,        16'h8000, 10'd0},    1'b0, '0}
   };

   stack_machine_execute dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .req_jump_target (req_jump_target),
      .req_var_index   (req_var_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_depth (rsp_stack_depth),
      .rsp_status      (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int operands_needed(op_type op);
      case (op)
         OP_POP, OP_STORE, OP_NOT, OP_JZ, OP_JP, OP_JM: return 1;
         OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND:         return 2;
         default:                                       return 0;
      endcase
   endfunction

   function automatic outcome_type execute_instruction(instruction_type ins);
      outcome_type res;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      logic [15:0] pc_next;
      logic        take;
      pc_next = program_counter + 16'd1;
      if (machine_status == ST_RUN) begin
         if (stack_count < operands_needed(ins.op)) begin
            machine_status = ST_UNDER;
         end else if ((ins.op == OP_PUSH || ins.op == OP_LOAD) && stack_count >= STACK_LIMIT) begin
            machine_status = ST_OVER;
         end else begin
            case (ins.op)
               OP_NOP: program_counter = pc_next;
               OP_PUSH, OP_LOAD: begin
                  operand_stack[stack_count] = (ins.op == OP_PUSH) ? ins.push
                                                                   : variables[ins.slot];
                  stack_count++;
                  program_counter = pc_next;
               end
               OP_POP: begin
                  stack_count--;
                  program_counter = pc_next;
               end
               OP_STORE: begin
                  stack_count--;
                  variables[ins.slot] = operand_stack[stack_count];
                  program_counter = pc_next;
               end
               OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND: begin
                  b = operand_stack[stack_count-1];
                  a = operand_stack[stack_count-2];
                  case (ins.op)
                     OP_ADD:  r = a + b;
                     OP_SUB:  r = a - b;
                     OP_MUL:  r = a * b;
                     OP_OR:   r = a | b;
                     default: r = a & b;
                  endcase
                  stack_count--;
                  operand_stack[stack_count-1] = r;
                  program_counter = pc_next;
               end
               OP_NOT: begin
                  operand_stack[stack_count-1] = (operand_stack[stack_count-1] == '0) ? 32'd1
                                                                                       : 32'd0;
                  program_counter = pc_next;
               end
               OP_JMP: program_counter = ins.target;
               OP_JZ, OP_JP, OP_JM: begin
                  a = operand_stack[stack_count-1];
                  stack_count--;
                  case (ins.op)
                     OP_JZ:   take = (a == '0);
                     OP_JP:   take = (a != '0) && !a[31];
                     default: take = a[31];
                  endcase
                  program_counter = take ? ins.target : pc_next;
               end
               default: machine_status = ST_HALT;
            endcase
         end
      end
      if (stack_count > deepest) deepest = stack_count;
      res.pc = program_counter;
      res.top = (stack_count > 0) ? operand_stack[stack_count-1] : '0;
      res.depth = stack_count[10:0];
      res.status = machine_status;
      return res;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'h1;
         2:       return 32'hffffffff;
         3:       return 32'h7fffffff;
         4:       return 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   // an instruction that keeps the machine running; push_pct biases the stack upwards
   function automatic instruction_type random_instruction(int push_pct);
      instruction_type ins;
      ins.push = random_word();
      ins.target = 16'($urandom_range(0, 16'hffff));
      ins.slot = 10'($urandom_range(0, 1) ? $urandom_range(0, VAR_SLOTS-1)
                                          : $urandom_range(0, 7));
      if ($urandom_range(0, 99) < push_pct)
         ins.op = $urandom_range(0, 1) ? OP_PUSH : OP_LOAD;
      else
         ins.op = op_type'($urandom_range(0, 14));
      if (operands_needed(ins.op) > stack_count)
         ins.op = OP_PUSH;
      if ((ins.op == OP_PUSH || ins.op == OP_LOAD) && stack_count >= STACK_LIMIT)
         ins.op = OP_POP;
      return ins;
   endfunction

   task automatic issue_instruction(input instruction_type ins, input logic typed,
                                    input outcome_type typed_outcome);
      outcome_type predicted;
      int          gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= ins.op;
      req_push_value <= ins.push;
      req_jump_target <= ins.target;
      req_var_index <= ins.slot;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = execute_instruction(ins);
      pending_results.push_back(typed ? typed_outcome : predicted);
      items_issued++;
   endtask

   task automatic check_result();
      outcome_type want;
      if (pending_results.size() == 0) begin
         $error("result item with nothing pending: next_pc %h", rsp_next_pc);
         mismatches++;
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (rsp_next_pc !== want.pc) begin
            $error("next_pc: expected %h, got %h", want.pc, rsp_next_pc);
            mismatches++;
         end
         if (rsp_top_value !== want.top) begin
            $error("top_value: expected %h, got %h", want.top, rsp_top_value);
            mismatches++;
         end
         if (rsp_stack_depth !== want.depth) begin
            $error("stack_depth: expected %0d, got %0d", want.depth, rsp_stack_depth);
            mismatches++;
         end
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            mismatches++;
         end
      end
   endtask

   // result side, back-pressure pattern and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         check_result();

      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end

      if (mode_age == 255) begin
         mode_age <= 0;
         stall_mode <= $urandom_range(0, 3);
      end else begin
         mode_age <= mode_age + 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 5) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_run > 0) begin
               rsp_stall <= 1'b1;
               stall_run <= stall_run - 1;
            end else if ($urandom_range(0, 9) == 0) begin
               rsp_stall <= 1'b1;
               stall_run <= $urandom_range(0, 23);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   initial begin
      instruction_type ins;
      op_type          closing_op;
      int              push_pct;
      for (int i = 0; i < VAR_SLOTS; i++) variables[i] = '0;
      for (int i = 0; i < STACK_LIMIT; i++) operand_stack[i] = '0;
      stop_plan = stop_plan_type'($urandom_range(0, 2));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_instruction(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].want);

      // mixed traffic, a climb to a full stack and a spell at the top unless the run
      // ends in an underflow, then mixed again; draining the stack counts in the total
      push_pct = 40;
      while (items_issued < DIRECTED_COUNT + 500) begin
         if (items_issued % 64 == 0) push_pct = $urandom_range(20, 60);
         issue_instruction(random_instruction(push_pct), 1'b0, '0);
      end
      if (stop_plan != STOP_BY_UNDERFLOW) begin
         while (stack_count < STACK_LIMIT)
            issue_instruction(random_instruction(90), 1'b0, '0);
         repeat (16) issue_instruction(random_instruction(60), 1'b0, '0);
      end
      while (items_issued + ((stop_plan == STOP_BY_UNDERFLOW) ? stack_count : 0)
             < DIRECTED_COUNT + RANDOM_ITEMS) begin
         if (items_issued % 64 == 0) push_pct = $urandom_range(20, 60);
         issue_instruction(random_instruction(push_pct), 1'b0, '0);
      end

      // bring the machine to a stop, then check that it stays stopped
      case (stop_plan)
         STOP_BY_HALT: begin
            ins = random_instruction(0);
            ins.op = OP_HALT;
            issue_instruction(ins, 1'b0, '0);
         end
         STOP_BY_OVERFLOW: begin
            while (machine_status == ST_RUN) begin
               ins = random_instruction(0);
               ins.op = $urandom_range(0, 1) ? OP_PUSH : OP_LOAD;
               issue_instruction(ins, 1'b0, '0);
            end
         end
         default: begin
            do closing_op = op_type'($urandom_range(1, 14));
            while (operands_needed(closing_op) == 0);
            while (machine_status == ST_RUN) begin
               ins = random_instruction(0);
               if (stack_count >= operands_needed(closing_op)) begin
                  do ins.op = op_type'($urandom_range(1, 14));
                  while (operands_needed(ins.op) != 1 || ins.op == OP_NOT);
               end else begin
                  ins.op = closing_op;
               end
               issue_instruction(ins, 1'b0, '0);
            end
         end
      endcase
      repeat (20) begin
         ins = random_instruction(0);
         ins.op = op_type'($urandom_range(0, 15));
         issue_instruction(ins, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d instructions issued, %0d results checked, deepest stack %0d",
               items_issued, results_checked, deepest);
      $display("machine brought to a stop by %s, status %0d", stop_plan.name(), machine_status);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
src/smx_pkg.sv
src/smx_var_store.sv
src/smx_stack_ram.sv
src/smx_exec.sv
src/stack_machine_execute.sv
test/testbench.sv
